// ===== rtl/salt_pkg.sv =====
// shared constants, types and codes of the set-associative lru tag store
package salt_pkg;

   localparam int MAX_WAYS   = 8;
   localparam int MAX_SETS   = 256;
   localparam int ADDR_WIDTH = 32;

   localparam int ADDR_W = 32;
   localparam int TAG_W  = ADDR_W;
   localparam int CFG_W  = 4;
   localparam int CSR_IDX_W = 2;
   localparam int KIND_W = 2;
   localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int RANK_W = WAY_W;
   localparam int WCNT_W = $clog2(MAX_WAYS + 1);

   localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);
   localparam logic [ADDR_W-1:0] ADDR_MASK =
      (ADDR_WIDTH >= ADDR_W) ? {ADDR_W{1'b1}} : ((ADDR_W'(1) << ADDR_WIDTH) - ADDR_W'(1));

   localparam logic [CFG_W-1:0] OFFSET_RESET = CFG_W'(6);
   localparam logic [CFG_W-1:0] INDEX_RESET  = CFG_W'(6);
   localparam logic [CFG_W-1:0] WAYS_RESET   = CFG_W'(8);

   typedef enum logic [KIND_W-1:0] {
      KIND_ACCESS = 2'd0,
      KIND_FILL   = 2'd1,
      KIND_INVAL  = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OFFSET_BITS = 2'd0,
      CSR_INDEX_BITS  = 2'd1,
      CSR_WAYS_IN_USE = 2'd2
   } csr_index_type;

   typedef logic [TAG_W-1:0] tag_type;
   typedef tag_type [MAX_WAYS-1:0] tag_row_type;

   typedef struct packed {
      logic              valid;
      logic [RANK_W-1:0] rank;
   } way_meta_type;

   typedef way_meta_type [MAX_WAYS-1:0] meta_row_type;

   typedef struct packed {
      logic hit;
      logic forward_miss;
   } rsp_flags_type;

   typedef struct packed {
      logic             meta_we;
      logic             tag_we;
      logic [WAY_W-1:0] tag_way;
   } wb_ctrl_type;

endpackage

// ===== rtl/salt_split.sv =====
// address split into set index and tag under the programmed field widths
module salt_split (
   input  logic [salt_pkg::ADDR_W-1:0] address,
   input  logic [salt_pkg::CFG_W-1:0]  offset_bits,
   input  logic [salt_pkg::CFG_W-1:0]  index_bits,
   output logic [salt_pkg::ADDR_W-1:0] addr_masked,
   output logic [salt_pkg::SET_W-1:0]  set_idx,
   output salt_pkg::tag_type           tag
);

   logic [salt_pkg::ADDR_W-1:0]  shifted;
   logic [2**salt_pkg::CFG_W-1:0] idx_mask;
   logic [salt_pkg::CFG_W:0]      tag_shift;

   always_comb begin
      addr_masked = address & salt_pkg::ADDR_MASK;
      shifted     = addr_masked >> offset_bits;
      idx_mask    = (2**salt_pkg::CFG_W)'((17'(1) << index_bits) - 17'(1));
      set_idx     = salt_pkg::SET_W'(shifted[2**salt_pkg::CFG_W-1:0] & idx_mask);
      tag_shift   = {1'b0, offset_bits} + {1'b0, index_bits};
      tag         = salt_pkg::TAG_W'(addr_masked >> tag_shift);
   end

endmodule

// ===== rtl/salt_set_mem.sv =====
// tag and recency memories, one set row per address, with per-row written flags
module salt_set_mem (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [salt_pkg::SET_W-1:0]   rd_set,
   output salt_pkg::tag_row_type        rd_tags,
   output salt_pkg::meta_row_type       rd_meta,
   input  logic [salt_pkg::SET_W-1:0]   wr_set,
   input  salt_pkg::wb_ctrl_type        wr_ctrl,
   input  salt_pkg::tag_type            wr_tag,
   input  salt_pkg::meta_row_type       wr_meta
);

   salt_pkg::tag_row_type  tag_mem  [salt_pkg::MAX_SETS];
   salt_pkg::meta_row_type meta_mem [salt_pkg::MAX_SETS];

   logic [salt_pkg::MAX_SETS-1:0] row_live_ff, row_live_in;
   salt_pkg::tag_row_type         rd_tags_ff;
   salt_pkg::meta_row_type        rd_meta_ff;
   logic                          rd_live_ff;

   always_ff @(posedge clock) begin
      if (wr_ctrl.tag_we) begin
         tag_mem[wr_set][wr_ctrl.tag_way] <= wr_tag;
      end
      if (wr_ctrl.meta_we) begin
         meta_mem[wr_set] <= wr_meta;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_tags_ff <= tag_mem[rd_set];
         rd_meta_ff <= meta_mem[rd_set];
      end
   end

   // rows never written read as cleared
   always_comb begin
      row_live_in = row_live_ff;
      if (wr_ctrl.meta_we) begin
         row_live_in[wr_set] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_live_ff <= '0;
         rd_live_ff  <= 1'b0;
      end else begin
         row_live_ff <= row_live_in;
         if (rd_en) begin
            rd_live_ff <= row_live_ff[rd_set];
         end
      end
   end

   assign rd_tags = rd_tags_ff;
   assign rd_meta = rd_live_ff ? rd_meta_ff : '0;

endmodule

// ===== rtl/salt_update.sv =====
// set lookup, replacement choice and recency update for one item
module salt_update (
   input  logic [salt_pkg::KIND_W-1:0] kind,
   input  salt_pkg::tag_type           tag,
   input  logic [salt_pkg::WCNT_W-1:0] ways_n,
   input  salt_pkg::tag_row_type       tags,
   input  salt_pkg::meta_row_type      meta,
   output salt_pkg::rsp_flags_type     flags,
   output salt_pkg::wb_ctrl_type       wb,
   output salt_pkg::meta_row_type      new_meta
);

   logic [salt_pkg::MAX_WAYS-1:0] in_use;
   logic [salt_pkg::MAX_WAYS-1:0] match;
   logic [salt_pkg::MAX_WAYS-1:0] free;
   logic [salt_pkg::WAY_W-1:0]    found_way;
   logic [salt_pkg::WAY_W-1:0]    free_way;
   logic [salt_pkg::WAY_W-1:0]    victim_way;
   logic [salt_pkg::RANK_W-1:0]   victim_rank;
   logic [salt_pkg::RANK_W-1:0]   found_rank;
   logic                          present;
   logic                          free_found;
   logic                          do_promote;
   logic                          age_all;
   logic [salt_pkg::WAY_W-1:0]    pr_way;
   logic [salt_pkg::RANK_W-1:0]   pr_limit;
   logic                          do_drop;

   always_comb begin
      found_way   = '0;
      free_way    = '0;
      for (int i = salt_pkg::MAX_WAYS - 1; i >= 0; i--) begin
         in_use[i] = salt_pkg::WCNT_W'(i) < ways_n;
         match[i]  = in_use[i] && meta[i].valid && (tags[i] == tag);
         free[i]   = in_use[i] && !meta[i].valid;
         if (match[i]) begin
            found_way = salt_pkg::WAY_W'(i);
         end
         if (free[i]) begin
            free_way = salt_pkg::WAY_W'(i);
         end
      end
      present    = |match;
      free_found = |free;
      found_rank = meta[found_way].rank;

      victim_way  = '0;
      victim_rank = meta[0].rank;
      for (int i = 1; i < salt_pkg::MAX_WAYS; i++) begin
         if (in_use[i] && (meta[i].rank > victim_rank)) begin
            victim_way  = salt_pkg::WAY_W'(i);
            victim_rank = meta[i].rank;
         end
      end
   end

   always_comb begin
      flags      = '0;
      wb         = '0;
      do_promote = 1'b0;
      age_all    = 1'b0;
      pr_way     = found_way;
      pr_limit   = found_rank;
      do_drop    = 1'b0;
      case (kind)
         salt_pkg::KIND_ACCESS: begin
            flags.hit          = present;
            flags.forward_miss = !present;
            wb.meta_we         = 1'b1;
            do_promote         = present;
         end
         salt_pkg::KIND_FILL: begin
            flags.hit  = present;
            wb.meta_we = 1'b1;
            do_promote = 1'b1;
            if (!present) begin
               wb.tag_we = 1'b1;
               if (free_found) begin
                  pr_way  = free_way;
                  age_all = 1'b1;
               end else begin
                  pr_way   = victim_way;
                  pr_limit = victim_rank;
               end
               wb.tag_way = pr_way;
            end
         end
         salt_pkg::KIND_INVAL: begin
            flags.hit  = present;
            wb.meta_we = 1'b1;
            do_drop    = present;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      new_meta = meta;
      if (do_promote) begin
         for (int i = 0; i < salt_pkg::MAX_WAYS; i++) begin
            if (in_use[i] && (salt_pkg::WAY_W'(i) != pr_way) && meta[i].valid &&
                (age_all || (meta[i].rank < pr_limit)) && (meta[i].rank != salt_pkg::RANK_MAX)) begin
               new_meta[i].rank = meta[i].rank + salt_pkg::RANK_W'(1);
            end
         end
         new_meta[pr_way].rank  = '0;
         new_meta[pr_way].valid = 1'b1;
      end
      if (do_drop) begin
         for (int i = 0; i < salt_pkg::MAX_WAYS; i++) begin
            if (in_use[i] && (salt_pkg::WAY_W'(i) != found_way) && meta[i].valid &&
                (meta[i].rank > found_rank)) begin
               new_meta[i].rank = meta[i].rank - salt_pkg::RANK_W'(1);
            end
         end
         new_meta[found_way].valid = 1'b0;
      end
   end

endmodule

// ===== rtl/set_assoc_lru_tag_store.sv =====
// top level of the set-associative lru tag store
//
// Each item passes a read step and then a compare step: the set row is read from the synchronous
// tag and recency memories, then all ways are compared, the replacement way is chosen
// and the updated row is written back while the result is loaded into the output register.
// One item is in flight at a time, so no new item is taken until the last one has left its
// compare stage; a result left waiting holds the next item in its compare stage. The
// store is usable straight out of reset: each set row carries a flag, cleared by reset, and
// a row never written reads as all ways invalid. Configuration writes are taken in any
// cycle and must only be made while no item is in flight.
module set_assoc_lru_tag_store (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [salt_pkg::KIND_W-1:0]    req_kind,
   input  logic [salt_pkg::ADDR_W-1:0]    req_address,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_hit,
   output logic                           rsp_forward_miss,
   output logic [salt_pkg::ADDR_W-1:0]    rsp_forward_address,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [salt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [salt_pkg::CFG_W-1:0]     csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_LOOK = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic [salt_pkg::CFG_W-1:0] offset_bits_ff, offset_bits_in;
   logic [salt_pkg::CFG_W-1:0] index_bits_ff, index_bits_in;
   logic [salt_pkg::CFG_W-1:0] ways_in_use_ff, ways_in_use_in;

   logic [salt_pkg::KIND_W-1:0] kind_ff, kind_in;
   salt_pkg::tag_type           tag_ff, tag_in;
   logic [salt_pkg::SET_W-1:0]  set_ff, set_in;
   logic [salt_pkg::ADDR_W-1:0] addr_ff, addr_in;
   logic [salt_pkg::WCNT_W-1:0] ways_n_ff, ways_n_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   salt_pkg::rsp_flags_type     rsp_flags_ff, rsp_flags_in;
   logic [salt_pkg::ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;

   logic                        req_xfer;
   logic                        advance;
   logic [salt_pkg::ADDR_W-1:0] split_addr;
   logic [salt_pkg::SET_W-1:0]  split_set;
   salt_pkg::tag_type           split_tag;
   salt_pkg::tag_row_type       rd_tags;
   salt_pkg::meta_row_type      rd_meta;
   salt_pkg::rsp_flags_type     upd_flags;
   salt_pkg::wb_ctrl_type       upd_wb;
   salt_pkg::wb_ctrl_type       mem_wb;
   salt_pkg::meta_row_type      upd_meta;

   salt_split u_split (
      .address     (req_address),
      .offset_bits (offset_bits_ff),
      .index_bits  (index_bits_ff),
      .addr_masked (split_addr),
      .set_idx     (split_set),
      .tag         (split_tag)
   );

   salt_set_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_xfer),
      .rd_set  (split_set),
      .rd_tags (rd_tags),
      .rd_meta (rd_meta),
      .wr_set  (set_ff),
      .wr_ctrl (mem_wb),
      .wr_tag  (tag_ff),
      .wr_meta (upd_meta)
   );

   salt_update u_update (
      .kind     (kind_ff),
      .tag      (tag_ff),
      .ways_n   (ways_n_ff),
      .tags     (rd_tags),
      .meta     (rd_meta),
      .flags    (upd_flags),
      .wb       (upd_wb),
      .new_meta (upd_meta)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign advance   = (state_ff == ST_LOOK) && (!rsp_valid_ff || rsp_ready);
   assign csr_ready = 1'b1;

   always_comb begin
      mem_wb = upd_wb;
      if (!advance) begin
         mem_wb = '0;
      end
   end

   // configuration registers
   always_comb begin
      offset_bits_in = offset_bits_ff;
      index_bits_in  = index_bits_ff;
      ways_in_use_in = ways_in_use_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            salt_pkg::CSR_OFFSET_BITS: offset_bits_in = csr_wdata;
            salt_pkg::CSR_INDEX_BITS:  index_bits_in  = csr_wdata;
            salt_pkg::CSR_WAYS_IN_USE: ways_in_use_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // item capture with associativity clamped to the built range
   always_comb begin
      kind_in   = kind_ff;
      tag_in    = tag_ff;
      set_in    = set_ff;
      addr_in   = addr_ff;
      ways_n_in = ways_n_ff;
      if (req_xfer) begin
         kind_in = req_kind;
         tag_in  = split_tag;
         set_in  = split_set;
         addr_in = split_addr;
         if (ways_in_use_ff == '0) begin
            ways_n_in = salt_pkg::WCNT_W'(1);
         end else if (int'(ways_in_use_ff) > salt_pkg::MAX_WAYS) begin
            ways_n_in = salt_pkg::WCNT_W'(salt_pkg::MAX_WAYS);
         end else begin
            ways_n_in = salt_pkg::WCNT_W'(ways_in_use_ff);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (advance) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_flags_in = rsp_flags_ff;
      rsp_addr_in  = rsp_addr_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_flags_in = upd_flags;
         rsp_addr_in  = upd_flags.forward_miss ? addr_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         offset_bits_ff <= salt_pkg::OFFSET_RESET;
         index_bits_ff  <= salt_pkg::INDEX_RESET;
         ways_in_use_ff <= salt_pkg::WAYS_RESET;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         offset_bits_ff <= offset_bits_in;
         index_bits_ff  <= index_bits_in;
         ways_in_use_ff <= ways_in_use_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      tag_ff       <= tag_in;
      set_ff       <= set_in;
      addr_ff      <= addr_in;
      ways_n_ff    <= ways_n_in;
      rsp_flags_ff <= rsp_flags_in;
      rsp_addr_ff  <= rsp_addr_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_hit             = rsp_flags_ff.hit;
   assign rsp_forward_miss    = rsp_flags_ff.forward_miss;
   assign rsp_forward_address = rsp_addr_ff;

endmodule

// ===== rtl/salt_checker.sv =====
// port-level checks of the tag store and their binding to the top level
module salt_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_hit,
   input logic                        rsp_forward_miss,
   input logic [salt_pkg::ADDR_W-1:0] rsp_forward_address
);

   // a waiting result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) &&
         $stable(rsp_forward_miss) && $stable(rsp_forward_address))
      else $error("stalled result changed");

   // one item in flight: no transfer right after a transfer
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while an item is in flight");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_forward_miss |-> !rsp_hit)
      else $error("miss forwarded on a hit");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_forward_miss |-> rsp_forward_address == '0)
      else $error("forward address set without a miss");

   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("result pending or input blocked after reset");

endmodule

bind set_assoc_lru_tag_store salt_checker u_salt_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_hit             (rsp_hit),
   .rsp_forward_miss    (rsp_forward_miss),
   .rsp_forward_address (rsp_forward_address)
);

// ===== tb/set_assoc_lru_tag_store_test.sv =====
`timescale 1ns / 100ps
// self-checking testbench of the set-associative lru tag store, checked against a built-in predictor
module set_assoc_lru_tag_store_test;

   localparam logic [salt_pkg::KIND_W-1:0]    KIND_UNUSED  = 2'd3;
   localparam logic [salt_pkg::CSR_IDX_W-1:0] CSR_UNUSED   = 2'd3;
   localparam int                             NUM_SETTINGS = 9;
   localparam int                             CHUNK_OPS    = 49;
   localparam int                             MAX_REPORTS  = 100;

   typedef struct packed {
      logic [salt_pkg::KIND_W-1:0] kind;
      logic [salt_pkg::ADDR_W-1:0] address;
   } tag_op_type;

   typedef struct packed {
      logic                        hit;
      logic                        forward_miss;
      logic [salt_pkg::ADDR_W-1:0] forward_address;
   } lookup_result_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [salt_pkg::KIND_W-1:0]    req_kind = '0;
   logic [salt_pkg::ADDR_W-1:0]    req_address = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic                           rsp_hit;
   logic                           rsp_forward_miss;
   logic [salt_pkg::ADDR_W-1:0]    rsp_forward_address;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [salt_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [salt_pkg::CFG_W-1:0]     csr_wdata = '0;

   tag_op_type        pending_ops[$];
   lookup_result_type lookup_results_q[$];
   lookup_result_type predicted;
   lookup_result_type oldest;
   tag_op_type        next_op;

   salt_pkg::tag_type           model_tag [salt_pkg::MAX_SETS][salt_pkg::MAX_WAYS];
   logic                        model_valid [salt_pkg::MAX_SETS][salt_pkg::MAX_WAYS];
   logic [salt_pkg::RANK_W-1:0] model_rank [salt_pkg::MAX_SETS][salt_pkg::MAX_WAYS];
   logic [salt_pkg::CFG_W-1:0]  cfg_offset = salt_pkg::OFFSET_RESET;
   logic [salt_pkg::CFG_W-1:0]  cfg_index  = salt_pkg::INDEX_RESET;
   logic [salt_pkg::CFG_W-1:0]  cfg_ways   = salt_pkg::WAYS_RESET;

   int send_idle_pct   = 0;
   int recv_stall_pct  = 0;
   int hold_off_cycles = 0;
   int mismatches      = 0;
   int ops_accepted    = 0;
   int hits_seen       = 0;
   int misses_fwd      = 0;
   int fills_seen      = 0;
   int invals_seen     = 0;

   set_assoc_lru_tag_store dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_address         (req_address),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_hit             (rsp_hit),
      .rsp_forward_miss    (rsp_forward_miss),
      .rsp_forward_address (rsp_forward_address),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic void make_most_recent(int set_num, int way, int limit, int n);
      for (int i = 0; i < n; i++) begin
         if (i != way && model_valid[set_num][i] && int'(model_rank[set_num][i]) < limit &&
             model_rank[set_num][i] < salt_pkg::RANK_MAX)
            model_rank[set_num][i]++;
      end
      model_rank[set_num][way] = '0;
   endfunction

   function automatic lookup_result_type predict_lookup(logic [salt_pkg::KIND_W-1:0] kind,
                                                        logic [salt_pkg::ADDR_W-1:0] address);
      logic [63:0]       wide;
      logic [63:0]       tag_wide;
      salt_pkg::tag_type tag_val;
      int                set_num, n, found, victim, way, r;
      bit                present, free_found;
      lookup_result_type res;
      wide = 64'(address);
      set_num = int'(((wide >> cfg_offset) & ((64'd1 << cfg_index) - 64'd1)) %
                     salt_pkg::MAX_SETS);
      tag_wide = wide >> (int'(cfg_offset) + int'(cfg_index));
      tag_val = tag_wide[salt_pkg::TAG_W-1:0];
      n = (cfg_ways == 0) ? 1 : (cfg_ways > salt_pkg::MAX_WAYS) ? salt_pkg::MAX_WAYS :
          int'(cfg_ways);
      present = 1'b0;
      found = 0;
      for (int i = 0; i < n; i++) begin
         if (!present && model_valid[set_num][i] && model_tag[set_num][i] == tag_val) begin
            present = 1'b1;
            found = i;
         end
      end
      res = '0;
      if (kind == KIND_UNUSED)
         return res;
      res.hit = present;
      case (kind)
         salt_pkg::KIND_ACCESS: begin
            if (present) begin
               make_most_recent(set_num, found, int'(model_rank[set_num][found]), n);
            end else begin
               res.forward_miss = 1'b1;
               res.forward_address = address;
            end
         end
         salt_pkg::KIND_FILL: begin
            if (present) begin
               make_most_recent(set_num, found, int'(model_rank[set_num][found]), n);
            end else begin
               free_found = 1'b0;
               way = 0;
               for (int i = 0; i < n; i++) begin
                  if (!free_found && !model_valid[set_num][i]) begin
                     free_found = 1'b1;
                     way = i;
                  end
               end
               if (free_found) begin
                  make_most_recent(set_num, way, salt_pkg::MAX_WAYS, n);
               end else begin
                  victim = 0;
                  for (int i = 1; i < n; i++)
                     if (model_rank[set_num][i] > model_rank[set_num][victim]) victim = i;
                  way = victim;
                  make_most_recent(set_num, way, int'(model_rank[set_num][way]), n);
               end
               model_tag[set_num][way] = tag_val;
               model_valid[set_num][way] = 1'b1;
            end
         end
         default: begin
            if (present) begin
               r = int'(model_rank[set_num][found]);
               model_valid[set_num][found] = 1'b0;
               for (int i = 0; i < n; i++)
                  if (model_valid[set_num][i] && int'(model_rank[set_num][i]) > r)
                     model_rank[set_num][i]--;
            end
         end
      endcase
      return res;
   endfunction

   function automatic logic [salt_pkg::ADDR_W-1:0] make_address();
      logic [63:0] set_part, tag_part, off_mask, idx_mask, wide;
      int          split;
      if ($urandom_range(99) < 8)
         return $urandom;
      split = int'(cfg_offset) + int'(cfg_index);
      off_mask = (64'd1 << cfg_offset) - 64'd1;
      idx_mask = (64'd1 << cfg_index) - 64'd1;
      set_part = ($urandom_range(3) < 3) ? 64'($urandom_range(3)) : 64'($urandom);
      tag_part = ($urandom_range(9) == 0) ? 64'($urandom) : 64'($urandom_range(11));
      wide = (tag_part << split) | ((set_part & idx_mask) << cfg_offset) |
             (64'($urandom) & off_mask);
      return wide[salt_pkg::ADDR_W-1:0];
   endfunction

   function automatic tag_op_type random_op();
      tag_op_type op;
      int         pick;
      pick = $urandom_range(99);
      op.address = make_address();
      if (pick < 45)      op.kind = salt_pkg::KIND_ACCESS;
      else if (pick < 80) op.kind = salt_pkg::KIND_FILL;
      else if (pick < 95) op.kind = salt_pkg::KIND_INVAL;
      else                op.kind = KIND_UNUSED;
      return op;
   endfunction

   task automatic report_mismatch(string what, logic [salt_pkg::ADDR_W-1:0] got,
                                  logic [salt_pkg::ADDR_W-1:0] want);
      if (mismatches < MAX_REPORTS)
         $display("mismatch on %s at %0t: got %h, want %h", what, $time, got, want);
      mismatches++;
   endtask

   task automatic queue_op(logic [salt_pkg::KIND_W-1:0] kind,
                           logic [salt_pkg::ADDR_W-1:0] address);
      pending_ops.insert(pending_ops.size(), tag_op_type'{kind: kind, address: address});
   endtask

   task automatic queue_random(int count);
      for (int i = 0; i < count; i++)
         pending_ops.insert(pending_ops.size(), random_op());
   endtask

   task automatic set_idling(int mode);
      @(negedge clock);
      case (mode)
         1:       begin send_idle_pct = 83; recv_stall_pct = 0;  end
         2:       begin send_idle_pct = 0;  recv_stall_pct = 83; end
         3:       begin send_idle_pct = 7;  recv_stall_pct = 7;  end
         default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
   endtask

   task automatic wait_sent();
      do @(negedge clock); while (pending_ops.size() != 0);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_ops.size() != 0 || req_valid || lookup_results_q.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(logic [salt_pkg::CSR_IDX_W-1:0] idx,
                            logic [salt_pkg::CFG_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         salt_pkg::CSR_OFFSET_BITS: cfg_offset = value;
         salt_pkg::CSR_INDEX_BITS:  cfg_index = value;
         salt_pkg::CSR_WAYS_IN_USE: cfg_ways = value;
         default: ;
      endcase
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predicted = predict_lookup(req_kind, req_address);
            lookup_results_q.insert(lookup_results_q.size(), predicted);
            ops_accepted++;
            if (predicted.hit) hits_seen++;
            if (predicted.forward_miss) misses_fwd++;
            if (req_kind == salt_pkg::KIND_FILL) fills_seen++;
            if (req_kind == salt_pkg::KIND_INVAL) invals_seen++;
         end
         if (!req_valid || req_ready) begin
            if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               next_op = pending_ops.pop_front();
               req_valid <= 1'b1;
               req_kind <= next_op.kind;
               req_address <= next_op.address;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (lookup_results_q.size() == 0) begin
               report_mismatch("unexpected transfer", rsp_forward_address, '0);
            end else begin
               oldest = lookup_results_q.pop_front();
               if (rsp_hit !== oldest.hit)
                  report_mismatch("hit", salt_pkg::ADDR_W'(rsp_hit),
                                  salt_pkg::ADDR_W'(oldest.hit));
               if (rsp_forward_miss !== oldest.forward_miss)
                  report_mismatch("forward_miss", salt_pkg::ADDR_W'(rsp_forward_miss),
                                  salt_pkg::ADDR_W'(oldest.forward_miss));
               if (rsp_forward_address !== oldest.forward_address)
                  report_mismatch("forward_address", rsp_forward_address,
                                  oldest.forward_address);
            end
         end
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   initial begin
      logic [salt_pkg::CFG_W-1:0] new_offset, new_index, new_ways;
      for (int s = 0; s < salt_pkg::MAX_SETS; s++)
         for (int w = 0; w < salt_pkg::MAX_WAYS; w++) begin
            model_valid[s][w] = 1'b0;
            model_rank[s][w] = '0;
         end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset split: set in bits 11:6, tag above
      set_idling(0);
      queue_op(salt_pkg::KIND_ACCESS, 32'h0000_0000);
      queue_op(salt_pkg::KIND_FILL, 32'h0000_0000);
      queue_op(salt_pkg::KIND_ACCESS, 32'h0000_0000);
      queue_op(salt_pkg::KIND_FILL, 32'h0000_0000);
      for (int t = 1; t <= 8; t++)
         queue_op(salt_pkg::KIND_FILL, 32'(t) << 12);
      queue_op(salt_pkg::KIND_ACCESS, 32'h0000_0000);
      queue_op(salt_pkg::KIND_ACCESS, 32'h0000_1000);
      queue_op(salt_pkg::KIND_INVAL, 32'h0000_3000);
      queue_op(salt_pkg::KIND_INVAL, 32'h0000_3000);
      queue_op(salt_pkg::KIND_FILL, 32'h0000_9000);
      queue_op(KIND_UNUSED, 32'hFFFF_FFFF);
      queue_op(salt_pkg::KIND_ACCESS, 32'hFFFF_FFFF);
      queue_op(salt_pkg::KIND_FILL, 32'hFFFF_FFFF);
      queue_op(salt_pkg::KIND_ACCESS, 32'hFFFF_FFFF);
      queue_op(salt_pkg::KIND_INVAL, 32'hFFFF_FFFF);
      queue_op(salt_pkg::KIND_ACCESS, 32'h0000_003F);
      wait_idle();

      for (int setting = 0; setting < NUM_SETTINGS; setting++) begin
         case (setting)
            0:       begin new_offset = 4'd0;  new_index = 4'd0;  new_ways = 4'd1;  end
            1:       begin new_offset = 4'd12; new_index = 4'd8;  new_ways = 4'd8;  end
            2:       begin new_offset = 4'd4;  new_index = 4'd3;  new_ways = 4'd2;  end
            3:       begin new_offset = 4'd2;  new_index = 4'd12; new_ways = 4'd0;  end
            4:       begin new_offset = 4'd6;  new_index = 4'd6;  new_ways = 4'd15; end
            5:       begin new_offset = 4'd0;  new_index = 4'd8;  new_ways = 4'd3;  end
            6:       begin new_offset = 4'd12; new_index = 4'd0;  new_ways = 4'd5;  end
            7: begin
               new_offset = salt_pkg::CFG_W'($urandom_range(12));
               new_index = salt_pkg::CFG_W'($urandom_range(8));
               new_ways = salt_pkg::CFG_W'($urandom_range(8, 1));
            end
            default: begin new_offset = 4'd6;  new_index = 4'd6;  new_ways = 4'd8;  end
         endcase
         if (setting == 4)
            write_csr(CSR_UNUSED, 4'hF);
         write_csr(salt_pkg::CSR_OFFSET_BITS, new_offset);
         write_csr(salt_pkg::CSR_INDEX_BITS, new_index);
         write_csr(salt_pkg::CSR_WAYS_IN_USE, new_ways);
         for (int chunk = 0; chunk < 3; chunk++) begin
            set_idling((setting + chunk) % 4);
            queue_random(CHUNK_OPS);
            wait_sent();
         end
         if (setting == 2) begin
            // long receiver hold-off with the sender still offering
            set_idling(0);
            hold_off_cycles = 400;
            queue_random(60);
            wait_sent();
         end
         wait_idle();
      end

      repeat (10) @(negedge clock);
      if (lookup_results_q.size() != 0)
         report_mismatch("results never delivered",
                         salt_pkg::ADDR_W'(lookup_results_q.size()), '0);
      $display("covered %0d operations: %0d hits, %0d forwarded misses, %0d fills, %0d invalidates",
               ops_accepted, hits_seen, misses_fwd, fills_seen, invals_seen);
      $display("over %0d register settings with sender gaps, receiver stalls and a long hold-off",
               NUM_SETTINGS + 1);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
